FILE: rtl/core/cppm_pulse_frame_decoder_macros.svh
// Assertion macros shared by the CPPM decoder RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef CPPM_PULSE_FRAME_DECODER_MACROS_SVH
`define CPPM_PULSE_FRAME_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
`define CPPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CPPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CPPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/cppm_pkg.sv
// Shared types and constants of the CPPM frame decoder.
// No dependencies; used by every other file of the block but the assertion macro header.
package cppm_pkg;

	localparam int MAX_CHANNELS_DEF = 16;

	localparam int RATE_W  = 30;
	localparam int SYNC_W  = 16;
	localparam int MAXCH_W = 5;
	localparam int MINCH_W = 16;
	localparam int DIR_W   = 2;
	localparam int DELTA_W = 32;
	localparam int WIDTH_W = 32;
	localparam int CHAN_W  = 5;
	localparam int SUM_W   = DELTA_W + 1;
	localparam int US_W    = 20;
	localparam int PROD_W  = SUM_W + US_W;
	localparam int CFG_W   = RATE_W;
	localparam int IDX_W   = 3;

	localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

	typedef enum logic [IDX_W-1:0] {
		REG_SAMPLE_RATE = 3'd0,
		REG_SYNC_TIME   = 3'd1,
		REG_MAX_CHAN    = 3'd2,
		REG_MIN_CHANGE  = 3'd3,
		REG_SYNC_DIR    = 3'd4
	} cfg_reg_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_ANY  = 2'd0,
		DIR_LOW  = 2'd1,
		DIR_HIGH = 2'd2
	} sync_dir_t;

	typedef struct packed {
		logic [RATE_W-1:0]  sample_rate_hz;
		logic [SYNC_W-1:0]  sync_time_us;
		logic [MAXCH_W-1:0] max_channels;
		logic [MINCH_W-1:0] min_change_us;
		logic [DIR_W-1:0]   sync_direction;
	} cppm_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;      // latch edge, form sample count
		logic pair;         // sample count is first interval + delta
		logic store_first;  // keep delta as first interval of a pair
		logic div_start;    // scale to microseconds and start divide
		logic clear_count;  // frame sync seen
		logic commit;       // load result beat, update channel state
	} cppm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic sync_hit;
		logic out_free;
	} cppm_sts_t;

endpackage

FILE: rtl/core/cppm_in_if.sv
// Edge channel of the CPPM decoder: valid/ready plus edge payload.
// Depends on cppm_pkg.
interface cppm_in_if;
	import cppm_pkg::*;

	logic               valid;
	logic               ready;
	logic [DELTA_W-1:0] delta_samples;
	logic               new_level;

	modport source (output valid, output delta_samples, output new_level, input ready);
	modport sink (input valid, input delta_samples, input new_level, output ready);
endinterface

FILE: rtl/core/cppm_out_if.sv
// Result channel of the CPPM decoder: valid/ready plus result payload.
// Depends on cppm_pkg.
interface cppm_out_if;
	import cppm_pkg::*;

	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] width_us;
	logic [CHAN_W-1:0]  channel_number;
	logic               overflow_error;
	logic               changed;
	logic               went_up;

	modport source (output valid, output width_us, output channel_number,
		output overflow_error, output changed, output went_up, input ready);
	modport sink (input valid, input width_us, input channel_number,
		input overflow_error, input changed, input went_up, output ready);
endinterface

FILE: rtl/core/cppm_div.sv
// Restoring divider, one quotient bit per cycle, for the microsecond scale.
// Depends on cppm_pkg and the assertion macro header.
`include "cppm_pulse_frame_decoder_macros.svh"
module cppm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cppm_pkg::PROD_W-1:0]  dividend,
	input  logic [cppm_pkg::RATE_W-1:0]  divisor,
	output logic                         done,
	output logic [cppm_pkg::PROD_W-1:0]  quotient
);
	import cppm_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] dvd_q;
	logic [RATE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RATE_W:0] trial;
	logic [RATE_W:0] trial_sub;
	logic            ge;

	// zero divisor: every trial passes, quotient all ones, caller saturates
	assign trial     = {rem_q, dvd_q[PROD_W-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign ge        = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	`CPPM_ASSERT_NOW(a_div_no_restart, clk, arst_n, start, !busy_q, "divider restarted while busy")

endmodule

FILE: rtl/core/cppm_dpath.sv
// Datapath: edge capture, scaling, divider, channel tracking, result register.
// Depends on cppm_pkg, cppm_div, cppm_out_if and the assertion macro header.
`include "cppm_pulse_frame_decoder_macros.svh"
module cppm_dpath #(
	parameter int MAX_CHANNELS = cppm_pkg::MAX_CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cppm_pkg::cppm_cfg_t          cfg,
	input  logic [cppm_pkg::DELTA_W-1:0] delta_samples,
	input  logic                         new_level,
	input  cppm_pkg::cppm_cmd_t          cmd,
	output cppm_pkg::cppm_sts_t          sts,
	cppm_out_if.source                   result
);
	import cppm_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHANNELS + 2);
	localparam int LW_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CMP_W = ((CNT_W > MAXCH_W) ? CNT_W : MAXCH_W) + 1;

	logic [DELTA_W-1:0] first_q;
	logic [SUM_W-1:0]   sum_q;
	logic               level_q;
	logic [WIDTH_W-1:0] width_q;
	logic [CNT_W-1:0]   count_q;
	logic [WIDTH_W-1:0] last_q [MAX_CHANNELS];

	logic               out_valid_q;
	logic [WIDTH_W-1:0] out_width_q;
	logic [CHAN_W-1:0]  out_chan_q;
	logic               out_ovf_q;
	logic               out_chg_q;
	logic               out_up_q;

	logic [PROD_W-1:0]  dividend;
	logic [PROD_W-1:0]  quotient;
	logic               div_done;
	logic               level_ok;
	logic [CMP_W-1:0]   lim;
	logic [CMP_W-1:0]   cnt_next;
	logic               ovf;
	logic [LW_W-1:0]    idx;
	logic [WIDTH_W-1:0] stored;
	logic [WIDTH_W-1:0] diff;
	logic               up;
	logic               chg;
	logic [CHAN_W-1:0]  chan_out;

	assign dividend = PROD_W'(sum_q) * PROD_W'(US_PER_S);

	cppm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (cfg.sample_rate_hz),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		unique case (cfg.sync_direction)
			DIR_LOW:  level_ok = !level_q;
			DIR_HIGH: level_ok = level_q;
			default:  level_ok = 1'b1;
		endcase
	end

	assign lim      = (CMP_W'(cfg.max_channels) < CMP_W'(MAX_CHANNELS)) ?
		CMP_W'(cfg.max_channels) : CMP_W'(MAX_CHANNELS);
	assign cnt_next = CMP_W'(count_q) + CMP_W'(1);
	assign ovf      = cnt_next > lim;
	assign idx      = count_q[LW_W-1:0];
	assign stored   = last_q[idx];
	assign up       = width_q > stored;
	assign diff     = up ? (width_q - stored) : (stored - width_q);
	assign chg      = !ovf && (diff != '0) && (diff >= WIDTH_W'(cfg.min_change_us));
	assign chan_out = ovf ? CHAN_W'(1) : cnt_next[CHAN_W-1:0];

	assign sts.div_done = div_done;
	assign sts.sync_hit = (width_q >= WIDTH_W'(cfg.sync_time_us)) && level_ok;
	assign sts.out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				last_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store_first) begin
				first_q <= delta_samples;
			end
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.commit) begin
				count_q <= ovf ? '0 : cnt_next[CNT_W-1:0];
				if (chg) begin
					last_q[idx] <= width_q;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sum_q   <= cmd.pair ? ({1'b0, first_q} + {1'b0, delta_samples})
				: {1'b0, delta_samples};
			level_q <= new_level;
		end
		if (div_done) begin
			width_q <= (|quotient[PROD_W-1:WIDTH_W]) ? '1 : quotient[WIDTH_W-1:0];
		end
		if (cmd.commit) begin
			out_width_q <= width_q;
			out_chan_q  <= chan_out;
			out_ovf_q   <= ovf;
			out_chg_q   <= chg;
			out_up_q    <= chg && up;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.width_us       = out_width_q;
	assign result.channel_number = out_chan_q;
	assign result.overflow_error = out_ovf_q;
	assign result.changed        = out_chg_q;
	assign result.went_up        = out_up_q;

	`CPPM_ASSERT_NOW(a_commit_free, clk, arst_n, cmd.commit, !out_valid_q || result.ready, "result beat overwritten")
	`CPPM_ASSERT_NEXT(a_ovf_clears, clk, arst_n, cmd.commit && ovf, count_q == '0, "channel count not cleared on overflow")

endmodule

FILE: rtl/core/cppm_ctrl.sv
// Controller: sync hunt / pair tracking and sequencing of one edge at a time.
// Depends on cppm_pkg and the assertion macro header.
`include "cppm_pulse_frame_decoder_macros.svh"
module cppm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cppm_pkg::cppm_sts_t sts,
	output cppm_pkg::cppm_cmd_t cmd
);
	import cppm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EVAL = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   locked_q, locked_d;
	logic   second_q, second_d;
	logic   pair_q, pair_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		locked_d = locked_q;
		second_d = second_q;
		pair_d   = pair_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!locked_q) begin
						cmd.capture = 1'b1;
						pair_d      = 1'b0;
						state_d     = ST_MUL;
					end else if (!second_q) begin
						cmd.store_first = 1'b1;
						second_d        = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						cmd.pair    = 1'b1;
						pair_d      = 1'b1;
						second_d    = 1'b0;
						state_d     = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!pair_q) begin
					if (sts.sync_hit) begin
						locked_d = 1'b1;
						second_d = 1'b0;
					end
					state_d = ST_IDLE;
				end else if (sts.sync_hit) begin
					cmd.clear_count = 1'b1;
					state_d         = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			locked_q <= 1'b0;
			second_q <= 1'b0;
			pair_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			locked_q <= locked_d;
			second_q <= second_d;
			pair_q   <= pair_d;
		end
	end

	`CPPM_ASSERT_NOW(a_second_needs_lock, clk, arst_n, second_q, locked_q, "pair tracking while hunting")

endmodule

FILE: rtl/core/cppm_pulse_frame_decoder.sv
// CPPM pulse frame decoder, top level: configuration registers, controller, datapath.
// Depends on cppm_pkg, cppm_in_if, cppm_out_if, cppm_ctrl, cppm_dpath.
//
// Takes one beat per line edge (samples since the previous edge and the level
// after it) and hands out one beat per decoded channel period. After reset the
// block hunts for a gap of at least sync_time_us whose closing level passes the
// sync-direction check, then locks for good and pairs up edges. A pair at or
// above the sync time (with a good level) just restarts the channel count; any
// other pair gives a width in microseconds, floor(samples*1e6/sample_rate_hz)
// saturated to 32 bits, the channel number, an overflow flag (channel 1
// reported, count restarted) and a change flag with direction against that
// channel's last stored width. The first edge of a pair is only stored and the
// controller stays idle; every other edge is scaled and then divided by the
// bit-serial restoring divide (one quotient bit per cycle over the 53-bit scaled
// sample count) before it is evaluated. One edge is in flight at a time; the result
// register lets the next edge be accepted while a beat waits on the output. No
// clearing pass after reset. Configuration writes are applied at once and belong
// in idle time; an index beyond the register list is ignored.
module cppm_pulse_frame_decoder #(
	parameter int MAX_CHANNELS = cppm_pkg::MAX_CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [cppm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [cppm_pkg::CFG_W-1:0]   cfg_data,
	cppm_in_if.sink                      pulse,
	cppm_out_if.source                   result
);
	import cppm_pkg::*;

	cppm_cfg_t cfg_q;
	cppm_cmd_t cmd;
	cppm_sts_t sts;

	// register file, reset values as documented for the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate_hz <= RATE_W'(24000000);
			cfg_q.sync_time_us   <= SYNC_W'(2500);
			cfg_q.max_channels   <= MAXCH_W'(8);
			cfg_q.min_change_us  <= MINCH_W'(5);
			cfg_q.sync_direction <= DIR_ANY;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SAMPLE_RATE: cfg_q.sample_rate_hz <= cfg_data[RATE_W-1:0];
				REG_SYNC_TIME:   cfg_q.sync_time_us   <= cfg_data[SYNC_W-1:0];
				REG_MAX_CHAN:    cfg_q.max_channels   <= cfg_data[MAXCH_W-1:0];
				REG_MIN_CHANGE:  cfg_q.min_change_us  <= cfg_data[MINCH_W-1:0];
				REG_SYNC_DIR:    cfg_q.sync_direction <= cfg_data[DIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencing: hunt/lock, pair tracking, divider wait, result hand-off
	cppm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pulse.valid),
		.in_ready (pulse.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, channel store and output beat register
	cppm_dpath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.delta_samples (pulse.delta_samples),
		.new_level     (pulse.new_level),
		.cmd           (cmd),
		.sts           (sts),
		.result        (result)
	);

endmodule
